### hw/rtl/text_to_integer_any_base_top_macros.svh
// assertion macros shared by the rtl of the text to integer converter
// no dependencies; the asserting module provides clk and rst_n
`ifndef TEXT_TO_INTEGER_ANY_BASE_TOP_MACROS_SVH
`define TEXT_TO_INTEGER_ANY_BASE_TOP_MACROS_SVH

// checked only while out of reset
`define TTOI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TTOI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ttoi_pkg.sv
// shared codes, character constants and helpers of the text to integer converter
// no dependencies
package ttoi_pkg;

  localparam int unsigned ACC_W = 32;
  localparam int unsigned CH_W  = 8;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_CHAR   = 2'd2;

  localparam logic [CH_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CH_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS      = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS     = 8'h2D;
  localparam logic [CH_W-1:0] CH_LAST_PRNT = 8'd126;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // symbols that make the base unusable
  function automatic logic is_bad_symbol(input logic [CH_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c <= CH_SPACE) || (c > CH_LAST_PRNT);
  endfunction

endpackage

### hw/rtl/ttoi_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module ttoi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 92
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/text_to_integer_any_base_top.sv
// text to signed 32-bit integer converter in a base set by a loaded symbol table
// uses ttoi_pkg, ttoi_ram and text_to_integer_any_base_top_macros.svh
// one item at a time; clear, unused mode, whitespace, sign and trailing characters are handled in S_IDLE
// a table scan (symbol append, digit or first non-digit) reads one entry per cycle through S_RD and S_CMP,
// ending at a hit or at the last entry; a digit's hit then passes through S_MUL for its multiply-add
// end of string: S_EMIT loads out_valid once the output is free; synchronous reset, table contents are kept
`include "text_to_integer_any_base_top_macros.svh"

module text_to_integer_any_base_top #(
  parameter int unsigned MAX_BASE = 92
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_ch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic               out_base_ok
);

  localparam int unsigned CNT_W = $clog2(MAX_BASE + 1);
  localparam int unsigned IDX_W = $clog2(MAX_BASE);
  localparam int unsigned ACC_W = ttoi_pkg::ACC_W;
  localparam int unsigned CH_W  = ttoi_pkg::CH_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_MUL,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              invalid_r, invalid_nxt;
  ttoi_pkg::phase_t  phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              dup_r, dup_nxt;
  logic [CH_W-1:0]   key_r, key_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]  out_value_r, out_value_nxt;
  logic              out_base_ok_r, out_base_ok_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [CH_W-1:0]   ram_rdata;

  logic [CNT_W-1:0]  idx_plus;
  logic              hit;
  logic              last;
  logic              take_digit;
  logic              ok;
  logic              in_acc;

  ttoi_ram #(
    .WIDTH (CH_W),
    .DEPTH (MAX_BASE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_nxt),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign idx_plus = CNT_W'(idx_r) + CNT_W'(1);
  assign hit      = (ram_rdata == key_r);
  assign last     = (idx_plus == count_r);
  assign ok       = !invalid_r && (count_r >= CNT_W'(2));

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    invalid_nxt     = invalid_r;
    phase_nxt       = phase_r;
    neg_nxt         = neg_r;
    acc_nxt         = acc_r;
    idx_nxt         = idx_r;
    dup_nxt         = dup_r;
    key_nxt         = key_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_value_nxt   = out_value_r;
    out_base_ok_nxt = out_base_ok_r;
    ram_we          = 1'b0;
    ram_waddr       = count_r[IDX_W-1:0];
    ram_raddr       = '0;
    take_digit      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt = in_ch;
          case (in_mode)
            ttoi_pkg::MODE_CLEAR: begin
              count_nxt   = '0;
              invalid_nxt = 1'b0;
              phase_nxt   = ttoi_pkg::PH_SPACE;
              neg_nxt     = 1'b0;
              acc_nxt     = '0;
            end
            ttoi_pkg::MODE_APPEND: begin
              phase_nxt = ttoi_pkg::PH_SPACE;
              neg_nxt   = 1'b0;
              acc_nxt   = '0;
              if (count_r >= CNT_W'(MAX_BASE)) begin
                invalid_nxt = 1'b1;
              end else begin
                if (ttoi_pkg::is_bad_symbol(in_ch)) begin
                  invalid_nxt = 1'b1;
                end
                ram_we = 1'b1;
                if (count_r == '0) begin
                  count_nxt = count_r + CNT_W'(1);
                end else begin
                  // duplicate check over the entries already stored
                  dup_nxt   = 1'b1;
                  idx_nxt   = '0;
                  state_nxt = S_RD;
                end
              end
            end
            ttoi_pkg::MODE_CHAR: begin
              if (in_ch == ttoi_pkg::CH_NUL) begin
                state_nxt = S_EMIT;
              end else begin
                case (phase_r)
                  ttoi_pkg::PH_SPACE, ttoi_pkg::PH_SIGN: begin
                    if (phase_r == ttoi_pkg::PH_SPACE && ttoi_pkg::is_space(in_ch)) begin
                      phase_nxt = phase_r;
                    end else if (in_ch == ttoi_pkg::CH_MINUS) begin
                      neg_nxt   = !neg_r;
                      phase_nxt = ttoi_pkg::PH_SIGN;
                    end else if (in_ch == ttoi_pkg::CH_PLUS) begin
                      phase_nxt = ttoi_pkg::PH_SIGN;
                    end else begin
                      take_digit = 1'b1;
                    end
                  end
                  ttoi_pkg::PH_DIGIT: take_digit = 1'b1;
                  default: take_digit = 1'b0;
                endcase
                if (take_digit) begin
                  if (count_r == '0) begin
                    phase_nxt = ttoi_pkg::PH_DONE;
                  end else begin
                    phase_nxt = ttoi_pkg::PH_DIGIT;
                    dup_nxt   = 1'b0;
                    idx_nxt   = '0;
                    state_nxt = S_RD;
                  end
                end
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        ram_raddr = idx_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // ram data belongs to idx_r; the next entry is read in the same cycle
        if (hit) begin
          if (dup_r) begin
            invalid_nxt = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_MUL;
          end
        end else if (last) begin
          if (dup_r) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            phase_nxt = ttoi_pkg::PH_DONE;
          end
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_plus[IDX_W-1:0];
          ram_raddr = idx_plus[IDX_W-1:0];
        end
      end
      S_MUL: begin
        acc_nxt   = ACC_W'(acc_r * ACC_W'(count_r)) + ACC_W'(idx_r);
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_base_ok_nxt = ok;
          out_value_nxt   = ok ? (neg_r ? (ACC_W'(0) - acc_r) : acc_r) : '0;
          phase_nxt       = ttoi_pkg::PH_SPACE;
          neg_nxt         = 1'b0;
          acc_nxt         = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      invalid_r   <= 1'b0;
      phase_r     <= ttoi_pkg::PH_SPACE;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      invalid_r   <= invalid_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    dup_r         <= dup_nxt;
    key_r         <= key_nxt;
    out_value_r   <= out_value_nxt;
    out_base_ok_r <= out_base_ok_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_value   = signed'(out_value_r);
  assign out_base_ok = out_base_ok_r;

  `TTOI_ASSERT(a_scan_in_range, (state_r == S_CMP) |-> (CNT_W'(idx_r) < count_r), "scan past table end")
  `TTOI_ASSERT(a_count_max, count_r <= CNT_W'(MAX_BASE), "symbol count above table depth")
  `TTOI_ASSERT(a_nul_emits, (in_acc && in_mode == ttoi_pkg::MODE_CHAR && in_ch == ttoi_pkg::CH_NUL) |=> (state_r == S_EMIT), "end of string did not start emit")
  `TTOI_ASSERT(a_emit_loads, (state_r == S_EMIT && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE), "emit did not load the output item")
  `TTOI_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
